### sv/cbq_pkg.sv
// ============================================================================
// cbq_pkg
// Shared types, constants and the microprogram of the biquad cascade.
// ============================================================================
package cbq_pkg;

    localparam int MAX_SECTIONS_DEF  = 4;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int COEF_WIDTH_DEF    = 24;
    localparam int DELAY_WIDTH       = 48;
    localparam int ACC_WIDTH         = DELAY_WIDTH + 2;
    localparam int COEFS_PER_SECTION = 5;
    localparam int CMD_WIDTH         = 2;
    localparam int CSEL_WIDTH        = 3;
    localparam int STEP_WIDTH        = 4;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_FILTER = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [CSEL_WIDTH-1:0] C_B0 = 3'd0;
    localparam logic [CSEL_WIDTH-1:0] C_B1 = 3'd1;
    localparam logic [CSEL_WIDTH-1:0] C_B2 = 3'd2;
    localparam logic [CSEL_WIDTH-1:0] C_A1 = 3'd3;
    localparam logic [CSEL_WIDTH-1:0] C_A2 = 3'd4;

    typedef enum logic [1:0] {A_NONE, A_LD_ACC, A_LD_D1, A_SUB} t_aop;
    typedef enum logic [1:0] {B_NONE, B_LD, B_SUB} t_bop;
    typedef enum logic [1:0] {J_NONE, J_EMPTY, J_MORE} t_jmp;

    localparam logic [STEP_WIDTH-1:0] ST_RD_B0   = 4'd0;
    localparam logic [STEP_WIDTH-1:0] ST_MUL_B0  = 4'd1;
    localparam logic [STEP_WIDTH-1:0] ST_ACC_Y   = 4'd2;
    localparam logic [STEP_WIDTH-1:0] ST_ROUND   = 4'd3;
    localparam logic [STEP_WIDTH-1:0] ST_MUL_A1  = 4'd4;
    localparam logic [STEP_WIDTH-1:0] ST_SUB_A1  = 4'd5;
    localparam logic [STEP_WIDTH-1:0] ST_SUB_A2  = 4'd6;
    localparam logic [STEP_WIDTH-1:0] ST_WB      = 4'd7;
    localparam logic [STEP_WIDTH-1:0] ST_EMIT    = 4'd8;

    typedef struct packed {
        logic                  coef_rd;
        logic [CSEL_WIDTH-1:0] coef_sel;
        logic                  mul_en;
        logic                  mul_y;
        t_aop                  a_op;
        t_bop                  b_op;
        logic                  y_en;
        logic                  wb;
        t_jmp                  jmp;
        logic [STEP_WIDTH-1:0] target;
        logic                  emit;
    } t_ctrl;

    // control store: one word per step of a section
    function automatic t_ctrl ucode(input logic [STEP_WIDTH-1:0] step);
        t_ctrl cw;
        cw = '0;
        unique case (step)
            ST_RD_B0: begin
                cw.coef_rd  = 1'b1;
                cw.coef_sel = C_B0;
                cw.jmp      = J_EMPTY;
                cw.target   = ST_EMIT;
            end
            ST_MUL_B0: begin
                cw.coef_rd  = 1'b1;
                cw.coef_sel = C_B1;
                cw.mul_en   = 1'b1;
            end
            ST_ACC_Y: begin
                cw.coef_rd  = 1'b1;
                cw.coef_sel = C_B2;
                cw.mul_en   = 1'b1;
                cw.a_op     = A_LD_ACC;
            end
            ST_ROUND: begin
                cw.coef_rd  = 1'b1;
                cw.coef_sel = C_A1;
                cw.mul_en   = 1'b1;
                cw.y_en     = 1'b1;
                cw.a_op     = A_LD_D1;
            end
            ST_MUL_A1: begin
                cw.coef_rd  = 1'b1;
                cw.coef_sel = C_A2;
                cw.mul_en   = 1'b1;
                cw.mul_y    = 1'b1;
                cw.b_op     = B_LD;
            end
            ST_SUB_A1: begin
                cw.mul_en   = 1'b1;
                cw.mul_y    = 1'b1;
                cw.a_op     = A_SUB;
            end
            ST_SUB_A2: begin
                cw.b_op     = B_SUB;
            end
            ST_WB: begin
                cw.wb       = 1'b1;
                cw.jmp      = J_MORE;
                cw.target   = ST_RD_B0;
            end
            ST_EMIT: begin
                cw.emit     = 1'b1;
            end
            default: begin
                cw.emit     = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

### sv/cbq_datapath.sv
// ============================================================================
// cbq_datapath
// Shared multiplier, two accumulators, rounding and the delay term registers.
// ============================================================================
module cbq_datapath #(
    parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = cbq_pkg::COEF_WIDTH_DEF,
    parameter int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cbq_pkg::t_ctrl                 i_ctrl,
    input  logic                           i_start,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic                           i_clear,
    input  logic [SEC_W-1:0]               i_k,
    input  logic signed [COEF_WIDTH-1:0]   i_coef,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_sat
);
    import cbq_pkg::*;

    localparam int DW = DELAY_WIDTH;
    localparam int AW = ACC_WIDTH;
    localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int XW = (PW > DW) ? PW : DW;
    localparam int FS = COEF_WIDTH - 4;

    localparam logic signed [XW-1:0] P_HI = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [XW-1:0] P_LO = ~P_HI;
    localparam logic signed [AW-1:0] A_HI = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [AW-1:0] A_LO = ~A_HI;
    localparam logic signed [AW-1:0] Y_HI =
        {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] Y_LO = ~Y_HI;
    localparam logic signed [AW-1:0] RND  = {{(AW-FS){1'b0}}, 1'b1, {(FS-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [AW-1:0] v);
        logic signed [DW-1:0] res;
        if (v > A_HI) begin
            res = A_HI[DW-1:0];
        end else if (v < A_LO) begin
            res = A_LO[DW-1:0];
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_sat;
    logic signed [DW-1:0]           r_p;
    logic signed [AW-1:0]           r_a;
    logic signed [AW-1:0]           r_b;
    logic signed [DW-1:0]           r_d0 [0:MAX_SECTIONS-1];
    logic signed [DW-1:0]           r_d1 [0:MAX_SECTIONS-1];

    logic signed [SAMPLE_WIDTH-1:0] mul_op;
    logic signed [PW-1:0]           prod;
    logic signed [XW-1:0]           prod_x;
    logic signed [DW-1:0]           n_p;
    logic signed [AW-1:0]           rnd;
    logic signed [SAMPLE_WIDTH-1:0] n_y;
    logic                           y_clip;
    logic signed [DW-1:0]           d0_rd;
    logic signed [DW-1:0]           d1_rd;
    logic signed [AW-1:0]           p_x;

    assign mul_op = i_ctrl.mul_y ? r_y : r_x;
    assign prod   = i_coef * mul_op;
    assign prod_x = XW'(prod);
    assign d0_rd  = r_d0[i_k];
    assign d1_rd  = r_d1[i_k];
    assign p_x    = AW'(r_p);

    always_comb begin
        if (prod_x > P_HI) begin
            n_p = P_HI[DW-1:0];
        end else if (prod_x < P_LO) begin
            n_p = P_LO[DW-1:0];
        end else begin
            n_p = prod_x[DW-1:0];
        end
    end

    always_comb begin
        rnd    = (r_a + RND) >>> FS;
        y_clip = 1'b1;
        if (rnd > Y_HI) begin
            n_y = Y_HI[SAMPLE_WIDTH-1:0];
        end else if (rnd < Y_LO) begin
            n_y = Y_LO[SAMPLE_WIDTH-1:0];
        end else begin
            n_y    = rnd[SAMPLE_WIDTH-1:0];
            y_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p <= n_p;
        end
        unique case (i_ctrl.a_op)
            A_LD_ACC: r_a <= AW'(sat_dw(p_x + AW'(d0_rd)));
            A_LD_D1:  r_a <= p_x + AW'(d1_rd);
            A_SUB:    r_a <= r_a - p_x;
            default:  r_a <= r_a;
        endcase
        unique case (i_ctrl.b_op)
            B_LD:    r_b <= p_x;
            B_SUB:   r_b <= r_b - p_x;
            default: r_b <= r_b;
        endcase
        if (i_start) begin
            r_x <= i_x;
        end else if (i_ctrl.wb) begin
            r_x <= r_y;
        end
        if (i_start) begin
            r_y <= '0;
        end else if (i_ctrl.y_en) begin
            r_y <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_start) begin
            r_sat <= 1'b0;
        end else if (i_ctrl.y_en) begin
            r_sat <= r_sat | y_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_SECTIONS; i++) begin
                r_d0[i] <= '0;
                r_d1[i] <= '0;
            end
        end else if (i_ctrl.wb) begin
            r_d0[i_k] <= sat_dw(r_a);
            r_d1[i_k] <= sat_dw(r_b);
        end
    end

    assign o_y   = r_y;
    assign o_sat = r_sat;

endmodule

### sv/cascaded_biquad_iir_filter.sv
// ============================================================================
// cascaded_biquad_iir_filter
// Cascade of transposed direct form II biquads run by a microcoded sequencer.
// ============================================================================
// Input channel (i_valid/o_ready) carries one request: a sample to filter, a
// coefficient write or a delay clear. Output channel (o_valid/i_ready)
// carries one filtered sample and a saturation flag per sample request.
// i_cfg_wr_en/i_cfg_wr_data set the number of active sections; write it only
// while the block is idle.
// Write and clear requests give no result. A sample request runs the
// control store once per active section, over one shared multiplier and
// the single-port coefficient memory, plus one emit step that registers
// the result. o_ready is low while a sample is in flight, so a new request
// is taken only after the previous sample has reached the emit step and
// been registered.
// If the receiver stalls, the result waits in the output register; a
// following sample finishes its sections and then holds at the emit step
// until the output register is free.
// Reset clears the coefficients (by per-entry valid bits), the delay terms,
// the section count and the output valid flag.
// ============================================================================
module cascaded_biquad_iir_filter #(
    parameter int MAX_SECTIONS = cbq_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = cbq_pkg::COEF_WIDTH_DEF,
    parameter int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
    parameter int ACT_W        = $clog2(MAX_SECTIONS + 1),
    parameter int CFG_W        = (ACT_W > 3) ? ACT_W : 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [CFG_W-1:0]                 i_cfg_wr_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [cbq_pkg::CMD_WIDTH-1:0]    i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample_in,
    input  logic [SEC_W-1:0]                 i_coef_section,
    input  logic [cbq_pkg::CSEL_WIDTH-1:0]   i_coef_select,
    input  logic signed [COEF_WIDTH-1:0]     i_coef_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   o_sample_out,
    output logic                             o_saturated
);
    import cbq_pkg::*;

    localparam int NCOEF = MAX_SECTIONS * COEFS_PER_SECTION;
    localparam int CA_W  = $clog2(NCOEF);
    localparam logic [CA_W-1:0]  NC_C   = CA_W'(COEFS_PER_SECTION);
    localparam logic [ACT_W-1:0] MAX_C  = ACT_W'(MAX_SECTIONS);
    localparam logic [CFG_W-1:0] MAX_CF = CFG_W'(MAX_SECTIONS);

    logic [CFG_W-1:0]              r_active;
    logic                          r_busy;
    logic [STEP_WIDTH-1:0]         r_step;
    logic [STEP_WIDTH-1:0]         n_step;
    logic [SEC_W-1:0]              r_k;
    logic                          r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                          r_out_sat;
    logic signed [COEF_WIDTH-1:0]  r_cmem [0:NCOEF-1];
    logic [NCOEF-1:0]              r_cvalid;
    logic signed [COEF_WIDTH-1:0]  r_coef;

    t_ctrl                         ctrl;
    t_cmd                          cmd;
    logic                          accept;
    logic                          start;
    logic                          clear;
    logic                          cwr;
    logic [CA_W-1:0]               wr_addr;
    logic [CA_W-1:0]               rd_addr;
    logic [CFG_W-1:0]              n_clamp;
    logic [ACT_W-1:0]              n_sec;
    logic [ACT_W-1:0]              k_inc;
    logic                          out_free;
    logic                          emit_go;
    logic signed [SAMPLE_WIDTH-1:0] dp_y;
    logic                          dp_sat;

    assign o_ready  = !r_busy;
    assign accept   = i_valid && o_ready;
    assign cmd      = t_cmd'(i_cmd);
    assign ctrl     = r_busy ? ucode(r_step) : t_ctrl'('0);
    assign out_free = !r_out_valid || i_ready;
    assign emit_go  = ctrl.emit && out_free;

    assign n_clamp  = (r_active > MAX_CF) ? MAX_CF : r_active;
    assign n_sec    = n_clamp[ACT_W-1:0];
    assign k_inc    = ACT_W'(r_k) + ACT_W'(1);

    always_comb begin
        start = 1'b0;
        clear = 1'b0;
        cwr   = 1'b0;
        unique case (cmd)
            CMD_FILTER: start = accept;
            CMD_WRITE:  cwr   = accept && (ACT_W'(i_coef_section) < MAX_C)
                                && (i_coef_select < CSEL_WIDTH'(COEFS_PER_SECTION));
            CMD_CLEAR:  clear = accept;
            CMD_NONE:   start = 1'b0;
        endcase
    end

    assign wr_addr = CA_W'(i_coef_section) * NC_C + CA_W'(i_coef_select);
    assign rd_addr = CA_W'(r_k) * NC_C + CA_W'(ctrl.coef_sel);

    always_comb begin
        priority if (ctrl.jmp == J_EMPTY && n_sec == '0) begin
            n_step = ctrl.target;
        end else if (ctrl.jmp == J_MORE && k_inc < n_sec) begin
            n_step = ctrl.target;
        end else if (ctrl.emit) begin
            n_step = r_step;
        end else begin
            n_step = r_step + STEP_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_wr_en) begin
            r_active <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_RD_B0;
            r_k    <= '0;
        end else if (start) begin
            r_busy <= 1'b1;
            r_step <= ST_RD_B0;
            r_k    <= '0;
        end else if (r_busy) begin
            r_step <= n_step;
            if (ctrl.wb) begin
                r_k <= k_inc[SEC_W-1:0];
            end
            if (emit_go) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_sample <= dp_y;
            r_out_sat    <= dp_sat;
        end
    end

    // coefficient memory, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (cwr) begin
            r_cmem[wr_addr] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.coef_rd) begin
            r_coef <= r_cvalid[rd_addr] ? r_cmem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (cwr) begin
            r_cvalid[wr_addr] <= 1'b1;
        end
    end

    cbq_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .SEC_W        (SEC_W)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_start (start),
        .i_x     (i_sample_in),
        .i_clear (clear),
        .i_k     (r_k),
        .i_coef  (r_coef),
        .o_y     (dp_y),
        .o_sat   (dp_sat)
    );

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_saturated  = r_out_sat;

endmodule
